/* design/bha_pkg.sv */
// ----------------------------------------------------------------------------
// bha_pkg: shared types and codes for the bindless handle allocator
// Holds the channel payload structs, the command and status codes, the
// controller state type and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bha_pkg;

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP     = 2'd1;
  localparam logic [1:0] CMD_UNREGISTER = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  kind;
    logic [31:0] resource_handle;
    logic [7:0]  slot_index;
  } bha_in_t;

  typedef struct packed {
    logic [7:0]  assigned_index;
    logic [31:0] found_handle;
    logic [1:0]  status;
  } bha_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } bha_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the command and launch the table reads
    logic exec;  // apply the command and load the output register
  } bha_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a result this cycle
  } bha_sts_t;

endpackage

`default_nettype wire

/* design/bha_ctrl.sv */
// ----------------------------------------------------------------------------
// bha_ctrl: command sequencer for the bindless handle allocator
// Two-state machine: take a command and launch its reads, then apply it
// once the output register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module bha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire bha_pkg::bha_sts_t sts,
  output bha_pkg::bha_ctl_t      ctl,
  output logic                   in_stall
);

  bha_pkg::bha_state_t state_r;
  bha_pkg::bha_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      bha_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = bha_pkg::ST_EXEC;
        end
      end
      bha_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = bha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bha_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/bha_datapath.sv */
// ----------------------------------------------------------------------------
// bha_datapath: tables, free-index queue and result register
// Holds the handle, kind and occupied tables, the queue of freed indices,
// the high-water mark and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bha_datapath #(
  parameter int CAPACITY    = 256,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bha_pkg::bha_ctl_t ctl,
  input  wire bha_pkg::bha_in_t  in_data,
  input  wire logic              out_stall,
  output bha_pkg::bha_sts_t      sts,
  output logic                   out_valid,
  output bha_pkg::bha_out_t      out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int SW = HANDLE_BITS;
  localparam logic [AW-1:0] LAST_PTR = AW'(CAPACITY - 1);
  localparam logic [AW:0]   CAP_CNT  = (AW + 1)'(CAPACITY);

  // Tables. Entries at or above the high-water mark have never been written
  // and are never trusted, so the mark stands in for a clearing pass.
  logic [SW-1:0] handle_mem [CAPACITY];
  logic [1:0]    kind_mem   [CAPACITY];
  logic          occ_mem    [CAPACITY];
  logic [AW-1:0] fifo_mem   [CAPACITY];

  logic [1:0]    cmd_r;
  logic [1:0]    kind_r;
  logic [SW-1:0] handle_r;
  logic [7:0]    idx_r;
  logic [SW-1:0] hnd_rd_r;
  logic [1:0]    kind_rd_r;
  logic          occ_rd_r;
  logic [AW-1:0] fifo_rd_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic [AW:0]   hw_r, hw_nxt;

  logic              out_valid_r, out_valid_nxt;
  bha_pkg::bha_out_t out_data_r, out_data_nxt;

  logic [63:0]   in_h64;
  logic [63:0]   rd_h64;
  logic [CW-1:0] in_idx_ext;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] hw_ext;
  logic [CW-1:0] slot_ext;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] slot;
  logic [AW-1:0] wr_addr;
  logic          in_range;
  logic          tbl_wr;
  logic          occ_wr;
  logic          fifo_wr;

  assign in_h64     = 64'(in_data.resource_handle);
  assign rd_h64     = 64'(hnd_rd_r);
  assign in_idx_ext = CW'(in_data.slot_index);
  assign rd_addr    = in_idx_ext[AW-1:0];
  assign idx_ext    = CW'(idx_r);
  assign hw_ext     = CW'(hw_r);
  assign in_range   = idx_ext < hw_ext;
  assign slot       = (count_r != '0) ? fifo_rd_r : hw_r[AW-1:0];
  assign slot_ext   = CW'(slot);
  assign wr_addr    = (cmd_r == bha_pkg::CMD_REGISTER) ? slot : idx_ext[AW-1:0];

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // Command capture and registered table reads.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= in_data.command;
      kind_r    <= in_data.kind;
      handle_r  <= in_h64[SW-1:0];
      idx_r     <= in_data.slot_index;
      hnd_rd_r  <= handle_mem[rd_addr];
      kind_rd_r <= kind_mem[rd_addr];
      occ_rd_r  <= occ_mem[rd_addr];
      fifo_rd_r <= fifo_mem[head_r];
    end
  end

  // Table and queue writes.
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      handle_mem[wr_addr] <= handle_r;
      kind_mem[wr_addr]   <= kind_r;
    end
    if (occ_wr) begin
      occ_mem[wr_addr] <= tbl_wr;
    end
    if (fifo_wr) begin
      fifo_mem[tail_r] <= idx_ext[AW-1:0];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    hw_nxt        = hw_r;
    tbl_wr        = 1'b0;
    occ_wr        = 1'b0;
    fifo_wr       = 1'b0;
    out_data_nxt  = '0;
    out_data_nxt.status = bha_pkg::STS_NOT_FOUND;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.exec) begin
      out_valid_nxt = 1'b1;
      case (cmd_r)
        bha_pkg::CMD_REGISTER: begin
          if (count_r != '0) begin
            head_nxt  = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end else if (hw_r < CAP_CNT) begin
            hw_nxt = hw_r + 1'b1;
          end
          if (count_r != '0 || hw_r < CAP_CNT) begin
            tbl_wr = 1'b1;
            occ_wr = 1'b1;
            out_data_nxt.assigned_index = slot_ext[7:0];
            out_data_nxt.status         = bha_pkg::STS_OK;
          end else begin
            out_data_nxt.status = bha_pkg::STS_FULL;
          end
        end
        bha_pkg::CMD_LOOKUP: begin
          if (in_range && occ_rd_r && hnd_rd_r != '0 && kind_rd_r == kind_r) begin
            out_data_nxt.found_handle = rd_h64[31:0];
            out_data_nxt.status       = bha_pkg::STS_OK;
          end
        end
        bha_pkg::CMD_UNREGISTER: begin
          if (in_range && occ_rd_r && count_r < CAP_CNT) begin
            occ_wr    = 1'b1;
            fifo_wr   = 1'b1;
            tail_nxt  = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
            out_data_nxt.status = bha_pkg::STS_OK;
          end
        end
        default: begin
          out_data_nxt.status = bha_pkg::STS_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Freed indices all come from below the high-water mark.
  a_count_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hw_r)
    else $error("free queue holds more indices than were ever handed out");

  a_hw_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CAP_CNT)
    else $error("high-water mark passed capacity");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> out_valid_r)
    else $error("applied command produced no result");

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending output");

endmodule

`default_nettype wire

/* design/bindless_handle_allocator_top.sv */
// ----------------------------------------------------------------------------
// bindless_handle_allocator_top: table of resource handles with index reuse
// Register, lookup and unregister commands against a handle table, with a
// queue of freed indices that register takes from before fresh ones.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the in_ channel (in_valid, in_stall, in_data) and each
// one gives exactly one result on the out_ channel (out_valid, out_stall,
// out_data). A transfer takes place at a rising edge where valid is high
// and stall is low.
// A command is accepted in the idle state, which reads the handle,
// kind and occupied tables and the head of the free-index queue into
// registers; the execute state then applies the command, writes the tables
// and loads the result into the output register, once that register has
// room. A new command is taken only after the previous one has been applied.
// The result sits in its own register, so a new command is taken while a
// finished result still waits for the receiver.
// When the receiver holds out_stall, the pending result stays unchanged and
// the next command waits in the execute state, which holds in_stall high.
// Reset clears the queue pointers, the fill count of the queue, the
// high-water mark and the output valid flag; no clearing pass runs, because
// table entries at or above the high-water mark are never trusted. The block
// takes commands as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module bindless_handle_allocator_top #(
  parameter int CAPACITY    = 256,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bha_pkg::bha_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bha_pkg::bha_out_t      out_data
);

  // Command and status groups between the sequencer and the datapath.
  bha_pkg::bha_ctl_t ctl;
  bha_pkg::bha_sts_t sts;

  bha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  bha_datapath #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* dv/tb_bindless_handle_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bindless_handle_allocator_top: self-checking bench for the handle table
// Sends register, lookup and unregister commands through the valid/stall
// input channel and tracks the handle table, occupied bits, freed-index queue
// and high-water mark in a predictor of its own. Every result transfer is
// checked field by field against the oldest predicted result. A directed
// opening is followed by random traffic that fills the table to capacity and
// then churns it, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_bindless_handle_allocator_top;

  localparam int CAPACITY       = 256;
  localparam int ITEM_TARGET    = 450;
  localparam int CHUNK_ITEMS    = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int DRAIN_CYCLES   = 20;

  // The package names only the three real commands; the fourth code is the
  // undefined one, which the block must answer as not found.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [1:0] KIND_TEXTURE = 2'd0;
  localparam logic [1:0] KIND_BUFFER  = 2'd1;
  localparam logic [1:0] KIND_SAMPLER = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  bha_pkg::bha_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bha_pkg::bha_out_t out_data;

  bindless_handle_allocator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted allocator state. It advances once per accepted command, in the
  // driver, so it always reflects exactly the commands the block has taken.
  // --------------------------------------------------------------------------
  logic [31:0] handle_mem [CAPACITY];
  logic [1:0]  kind_mem   [CAPACITY];
  bit          occupied   [CAPACITY];
  logic [7:0]  free_queue [CAPACITY];
  int unsigned free_rd;
  int unsigned free_wr;
  int unsigned free_fill;
  int unsigned high_water;

  bha_pkg::bha_in_t  pending_cmds[$];      // commands waiting to be offered
  bha_pkg::bha_out_t expected_results[$];  // predicted results, oldest first
  int                error_count = 0;

  initial begin
    free_rd    = 0;
    free_wr    = 0;
    free_fill  = 0;
    high_water = 0;
    foreach (occupied[i]) occupied[i] = 1'b0;
  end

  // Appends a command to the tail of the pending queue.
  function automatic void add_cmd(input bha_pkg::bha_in_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Appends a predicted result to the tail of the expected queue.
  function automatic void add_result(input bha_pkg::bha_out_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Applies one command to the predicted state and returns its result.
  function automatic bha_pkg::bha_out_t apply_command(input bha_pkg::bha_in_t c);
    bha_pkg::bha_out_t r;
    int unsigned       slot;
    int unsigned       idx;
    r        = '0;
    r.status = bha_pkg::STS_NOT_FOUND;
    idx      = 32'(c.slot_index);
    case (c.command)
      bha_pkg::CMD_REGISTER: begin
        // Freed indices are reused oldest first before fresh ones are taken.
        if (free_fill > 0) begin
          slot      = 32'(free_queue[free_rd]);
          free_rd   = (free_rd + 1) % CAPACITY;
          free_fill = free_fill - 1;
        end else if (high_water < CAPACITY) begin
          slot       = high_water;
          high_water = high_water + 1;
        end else begin
          slot = CAPACITY;
        end
        if (slot < CAPACITY) begin
          handle_mem[slot]  = c.resource_handle;
          kind_mem[slot]    = c.kind;
          occupied[slot]    = 1'b1;
          r.assigned_index  = 8'(slot);
          r.status          = bha_pkg::STS_OK;
        end else begin
          r.status = bha_pkg::STS_FULL;
        end
      end
      bha_pkg::CMD_LOOKUP: begin
        if (idx < high_water && occupied[idx] && handle_mem[idx] != '0 &&
            kind_mem[idx] == c.kind) begin
          r.found_handle = handle_mem[idx];
          r.status       = bha_pkg::STS_OK;
        end
      end
      bha_pkg::CMD_UNREGISTER: begin
        if (idx < high_water && occupied[idx] && free_fill < CAPACITY) begin
          occupied[idx]       = 1'b0;
          handle_mem[idx]     = '0;
          free_queue[free_wr] = 8'(idx);
          free_wr             = (free_wr + 1) % CAPACITY;
          free_fill           = free_fill + 1;
          r.status            = bha_pkg::STS_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bha_pkg::bha_in_t make_cmd(input logic [1:0] command,
                                                input logic [1:0] kind,
                                                input logic [31:0] handle,
                                                input logic [7:0] slot);
    bha_pkg::bha_in_t c;
    c.command         = command;
    c.kind            = kind;
    c.resource_handle = handle;
    c.slot_index      = slot;
    return c;
  endfunction

  // Mostly random handles, with the all-zero and all-one extremes now and then.
  function automatic logic [31:0] random_handle();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Picks a slot for lookup or unregister: usually a live entry so that hits
  // and frees really happen, sometimes any entry below the high-water mark,
  // and sometimes anything the field allows.
  function automatic logic [7:0] pick_slot();
    int unsigned r;
    int unsigned start;
    int unsigned j;
    r = $urandom_range(0, 99);
    if (r < 70 && high_water > 0) begin
      start = $urandom_range(0, high_water - 1);
      for (int unsigned k = 0; k < high_water; k++) begin
        j = (start + k) % high_water;
        if (occupied[j]) return 8'(j);
      end
    end
    if (r < 85 && high_water > 0) return 8'($urandom_range(0, high_water - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds one random command from the given mix; whatever is left of the
  // hundred goes to the undefined command code.
  function automatic bha_pkg::bha_in_t random_command(input int reg_pct,
                                                      input int lookup_pct,
                                                      input int unreg_pct);
    bha_pkg::bha_in_t c;
    int unsigned      r;
    r                 = $urandom_range(0, 99);
    c.slot_index      = pick_slot();
    c.kind            = 2'($urandom_range(0, 3));
    c.resource_handle = random_handle();
    if (r < reg_pct) begin
      c.command = bha_pkg::CMD_REGISTER;
    end else if (r < reg_pct + lookup_pct) begin
      c.command = bha_pkg::CMD_LOOKUP;
      // Ask for the stored kind most of the time so that lookups can hit.
      if (occupied[c.slot_index] && $urandom_range(0, 9) < 7) c.kind = kind_mem[c.slot_index];
    end else if (r < reg_pct + lookup_pct + unreg_pct) begin
      c.command = bha_pkg::CMD_UNREGISTER;
    end else begin
      c.command = CMD_UNKNOWN;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Commands leave the pending queue in bursts of random length with
  // random gaps between them. A stalled transfer keeps its payload; the next
  // command is only loaded once the current one has been accepted.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) add_result(apply_command(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            // A third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It switches between stall patterns on a schedule of its own:
  // never stalling, stalling about half the time, and stalling rarely. Once,
  // after a fixed number of result transfers, it holds off for a long stretch
  // so that the output register fills and the block pushes back on its input.
  // --------------------------------------------------------------------------
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned drained_cnt  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) drained_cnt = drained_cnt + 1;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && drained_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 60);
        end else begin
          mode_left = mode_left - 1;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each result transfer is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  bha_pkg::bha_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("[%0t] unexpected result: expected none, actual idx=%0d handle=%h status=%0d",
                 $time, out_data.assigned_index, out_data.found_handle, out_data.status);
      end else begin
        want = expected_results.pop_front();
        if (out_data.assigned_index !== want.assigned_index) begin
          error_count++;
          $display("[%0t] assigned_index mismatch: expected %0d, actual %0d",
                   $time, want.assigned_index, out_data.assigned_index);
        end
        if (out_data.found_handle !== want.found_handle) begin
          error_count++;
          $display("[%0t] found_handle mismatch: expected %h, actual %h",
                   $time, want.found_handle, out_data.found_handle);
        end
        if (out_data.status !== want.status) begin
          error_count++;
          $display("[%0t] status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
        end
      end
    end
  end

  // The run ends here if no transfer happens on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
             $time, quiet, expected_results.size());
    $display("tb_bindless_handle_allocator_top NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run. The stimulus process works on falling edges so
  // that it never races the clocked driver over the pending queue.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned generated;
    generated = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Accesses on the empty table are out of range; then
    // the extreme handles, the zero handle and the spare kind code are stored
    // and looked up, a double free is tried, and freed slots are reused in
    // the order they were freed.
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_TEXTURE, 32'h0,         8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_UNREGISTER, KIND_TEXTURE, 32'h0,         8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_TEXTURE, 32'hFFFF_FFFF, 8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_BUFFER,  32'h0000_0001, 8'd255));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_SAMPLER, 32'h0,         8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_SPARE,   32'hA5A5_5A5A, 8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_TEXTURE, 32'h0,         8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_BUFFER,  32'h0,         8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_BUFFER,  32'hFFFF_FFFF, 8'd1));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_SAMPLER, 32'h0,         8'd2));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_SPARE,   32'h0,         8'd3));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_TEXTURE, 32'h0,         8'd255));
    add_cmd(make_cmd(CMD_UNKNOWN,             KIND_SPARE,   32'hFFFF_FFFF, 8'd255));
    add_cmd(make_cmd(bha_pkg::CMD_UNREGISTER, KIND_BUFFER,  32'h0,         8'd1));
    add_cmd(make_cmd(bha_pkg::CMD_UNREGISTER, KIND_BUFFER,  32'h0,         8'd1));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_BUFFER,  32'h0,         8'd1));
    add_cmd(make_cmd(bha_pkg::CMD_UNREGISTER, KIND_SAMPLER, 32'h0,         8'd2));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_TEXTURE, 32'h1234_5678, 8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_BUFFER,  32'h8000_0000, 8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_REGISTER,   KIND_SAMPLER, 32'h0F0F_F0F0, 8'd0));
    add_cmd(make_cmd(bha_pkg::CMD_UNREGISTER, KIND_TEXTURE, 32'h0,         8'd255));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_BUFFER,  32'h0,         8'd2));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_SAMPLER, 32'h0,         8'd4));
    add_cmd(make_cmd(bha_pkg::CMD_LOOKUP,     KIND_TEXTURE, 32'h0,         8'd1));

    // The sender pauses here until every directed result has come back.
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);

    // Random traffic in chunks. While the table still has fresh entries the
    // mix leans hard on register so that capacity is reached; after that it
    // churns: frees, reuse of freed slots and register on a full table.
    while (generated < ITEM_TARGET || (high_water < CAPACITY && generated < 3 * ITEM_TARGET))
    begin
      while (pending_cmds.size() > 0) @(negedge clk);
      repeat (CHUNK_ITEMS) begin
        if (high_water < CAPACITY) add_cmd(random_command(80, 12, 5));
        else                       add_cmd(random_command(35, 35, 25));
      end
      generated = generated + CHUNK_ITEMS;
    end

    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    // Keep the clock running so that any stray extra result is caught.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("tb_bindless_handle_allocator_top OK");
    end else begin
      $display("tb_bindless_handle_allocator_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
design/bha_pkg.sv
design/bha_ctrl.sv
design/bha_datapath.sv
design/bindless_handle_allocator_top.sv
dv/tb_bindless_handle_allocator_top.sv
